// ----- hw/rtl/dlst_pkg.sv -----
// Shared constants, codes, sigmoid table builder and saturation helper
// for the dense layer trainer. No dependencies.
`default_nettype none

package dlst_pkg;

    localparam int NUM_INPUTS  = 1024;
    localparam int NUM_OUTPUTS = 4;
    localparam int SIG_ENTRIES = 1024;

    localparam int ROW_W   = $clog2(NUM_INPUTS);
    localparam int CNT_W   = ROW_W + 1;
    localparam int NRN_W   = $clog2(NUM_OUTPUTS);
    localparam int SIG_AW  = $clog2(SIG_ENTRIES);
    localparam int SMP_W   = 16;
    localparam int WGT_W   = 32;
    localparam int LR_W    = 24;
    localparam int ACC_W   = SMP_W + WGT_W + CNT_W;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SAT_W   = 45;

    localparam logic [LR_W-1:0] LR_RESET = 24'd429497;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_GRAD    = 2'd1,
        OP_BPROP   = 2'd2,
        OP_WWRITE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_PRED  = 2'd0,
        KIND_BGRAD = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef logic [15:0] sig_table_t [SIG_ENTRIES];

    // Long division used only while the table is built at elaboration.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Sigmoid at the center of each interval over -8..+8, Q0.16.
    // e^-|x| via Taylor series of e^-(|x|/16), then squared four times.
    function automatic sig_table_t build_sig_table();
        sig_table_t        t;
        logic [63:0]       xu;
        logic signed [63:0] x;
        logic signed [63:0] e;
        logic [63:0]       s;
        logic [63:0]       term;
        logic [63:0]       ue;
        logic [63:0]       den;
        logic [63:0]       p;
        for (int i = 0; i < SIG_ENTRIES; i++) begin
            xu   = udiv64(64'(2 * i + 1) << 31, 64'(SIG_ENTRIES));
            x    = $signed(xu) - 64'sh8000_0000;
            s    = (x < 0) ? 64'(-x) : 64'(x);
            e    = 64'sh1_0000_0000;
            term = 64'h1_0000_0000;
            for (int n = 1; n <= 12; n++) begin
                term = udiv64((term * s) >> 32, 64'(n));
                if ((n & 1) == 1) e = e - $signed(term);
                else              e = e + $signed(term);
            end
            if (e < 0) e = 0;
            if (e > 64'sh0_FFFF_FFFF) e = 64'sh0_FFFF_FFFF;
            ue = 64'(e);
            for (int k = 0; k < 4; k++) ue = (ue * ue) >> 32;
            den = 64'h1_0000_0000 + ue;
            if (x >= 0) p = udiv64(64'h1 << 48, den);
            else        p = udiv64(ue << 16, den);
            t[i] = (p > 64'd65535) ? 16'hFFFF : p[15:0];
        end
        return t;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [31:0] r;
        if ((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31])) r = v[31:0];
        else if (v[SAT_W-1])                       r = 32'sh8000_0000;
        else                                       r = 32'sh7FFF_FFFF;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dense_layer_sigmoid_trainer.sv -----
// Four-neuron fully connected sigmoid layer with online SGD training.
// Depends on dlst_pkg and dlst_norm_div.
//
// Usage:
//   s_ channel: one item per op. tuser = op, tlast = last sample mark.
//   m_ channel: predictions (four per forward pass), back gradients (one
//   per backprop step) or one error item; tlast marks the final one.
//   cfg_we/cfg_wdata write the learning rate; the user must write it only
//   while the block is idle, which the block itself does not enforce.
// Steps per item:
//   load sample        stores it if there is room; a marked last sample
//                      adds the forward walk: each stored sample is
//                      normalized and accumulated, then predictions emitted.
//   gradient           updates one neuron's delta and bias.
//   backprop step      normalizes one sample, updates its weights, emits.
//   weight write       writes one weight word.
// Reset clears control state, biases, deltas and predictions and restores the
// default learning rate; sample and weight memories are not cleared. When the
// receiver stalls, the block holds its result and waits in the emitting state.
`default_nettype none

module dense_layer_sigmoid_trainer
    import dlst_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // tdata: sample[15:0], neuron[17:16], next_gradient[33:18],
    //        row[43:34], weight_value[75:44], zero pad
    input  wire logic [79:0]      s_tdata,
    input  wire logic [1:0]       s_tuser,   // op
    input  wire logic             s_tlast,   // last_sample
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // tdata: neuron_index[1:0], prediction[17:2], back_gradient[49:18],
    //        element_index[59:50], zero pad
    output logic [63:0]           m_tdata,
    output logic [1:0]            m_tuser,   // kind
    output logic                  m_tlast,   // last
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire logic             cfg_we,
    input  wire logic [LR_W-1:0]  cfg_wdata
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_F_SRD, ST_F_DGO, ST_F_DW, ST_F_WRD, ST_F_MUL, ST_F_ACC,
        ST_F_ACT, ST_F_PRED, ST_ERR, ST_G_M1, ST_G_M2, ST_G_M3, ST_G_WB,
        ST_B_SRD, ST_B_DGO, ST_B_DW, ST_B_WRD, ST_B_M1, ST_B_M2, ST_B_M3,
        ST_B_WB, ST_B_EMIT
    } state_t;

    localparam sig_table_t SIG_TABLE = build_sig_table();
    localparam logic [NRN_W-1:0] J_LAST = NRN_W'(NUM_OUTPUTS - 1);

    // control state
    state_t                  state_reg;
    logic [LR_W-1:0]         lr_reg;
    logic [CNT_W-1:0]        count_reg;
    logic signed [SMP_W-1:0] max_reg;
    logic                    image_done_reg;
    logic                    image_valid_reg;
    logic [CNT_W-1:0]        bp_ptr_reg;
    logic [ROW_W-1:0]        i_reg;
    logic [NRN_W-1:0]        j_reg;
    logic                    out_valid_reg;
    logic signed [31:0]      bias_reg  [NUM_OUTPUTS];
    logic [15:0]             pred_reg  [NUM_OUTPUTS];
    logic signed [31:0]      delta_reg [NUM_OUTPUTS];

    // result register
    kind_t                   out_kind_reg;
    logic [NRN_W-1:0]        out_nidx_reg;
    logic [15:0]             out_pred_reg;
    logic signed [31:0]      out_bg_reg;
    logic [ROW_W-1:0]        out_eidx_reg;
    logic                    out_last_reg;

    // datapath
    logic signed [ACC_W-1:0]  acc_reg [NUM_OUTPUTS];
    logic signed [PROD_W-1:0] bg_acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SMP_W-1:0]  x_reg;
    logic signed [SMP_W-1:0]  g_reg;
    logic [NRN_W-1:0]         n_reg;
    logic signed [WGT_W-1:0]  w_old_reg;
    logic [15:0]              rom_q_reg;

    // memories
    logic signed [SMP_W-1:0] smem [NUM_INPUTS];
    logic signed [WGT_W-1:0] wmem [NUM_INPUTS * NUM_OUTPUTS];
    logic signed [SMP_W-1:0] s_rd_reg;
    logic signed [WGT_W-1:0] w_rd_reg;

    // input unpack
    op_t                     s_op;
    logic signed [SMP_W-1:0] s_sample;
    logic [NRN_W-1:0]        s_neuron;
    logic signed [SMP_W-1:0] s_grad;
    logic [ROW_W-1:0]        s_row;
    logic signed [WGT_W-1:0] s_wval;
    logic                    s_accept;

    assign s_op     = op_t'(s_tuser);
    assign s_sample = s_tdata[15:0];
    assign s_neuron = s_tdata[17:16];
    assign s_grad   = s_tdata[33:18];
    assign s_row    = s_tdata[43:34];
    assign s_wval   = s_tdata[75:44];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    logic out_free;
    logic out_load;
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = out_free && ((state_reg == ST_F_PRED) || (state_reg == ST_ERR) ||
                                   (state_reg == ST_B_EMIT));

    // sample load bookkeeping; a new image restarts count and maximum
    logic [CNT_W-1:0]        eff_count;
    logic signed [SMP_W-1:0] eff_max;
    logic                    store_ok;
    logic signed [SMP_W-1:0] new_max;

    assign eff_count = image_done_reg ? '0 : count_reg;
    assign eff_max   = image_done_reg ? 16'sh8000 : max_reg;
    assign store_ok  = eff_count < CNT_W'(NUM_INPUTS);
    assign new_max   = (store_ok && (s_sample > eff_max)) ? s_sample : eff_max;

    logic walk_end;
    logic bp_last;
    assign walk_end = (CNT_W'(i_reg) + CNT_W'(1)) == count_reg;
    assign bp_last  = (bp_ptr_reg + CNT_W'(1)) == count_reg;

    // normalizer
    logic                    div_start;
    logic                    div_done;
    logic signed [SMP_W-1:0] div_quot;

    assign div_start = (state_reg == ST_F_DGO) || (state_reg == ST_B_DGO);

    dlst_norm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sample  (s_rd_reg),
        .max_val (max_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // shared multiplier operands
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [31:0]      grad_delta;

    assign grad_delta = $signed(prod_reg[47:16]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_F_MUL: begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(w_rd_reg);
            end
            ST_G_M1: begin
                mul_a = $signed(MUL_W'(pred_reg[n_reg]));
                mul_b = $signed(MUL_W'(17'h10000 - 17'(pred_reg[n_reg])));
            end
            ST_G_M2: begin
                mul_a = MUL_W'(g_reg);
                mul_b = $signed(prod_reg[32:0]);
            end
            ST_G_M3: begin
                mul_a = $signed(MUL_W'(lr_reg));
                mul_b = MUL_W'(grad_delta);
            end
            ST_B_M1: begin
                mul_a = MUL_W'(delta_reg[j_reg]);
                mul_b = MUL_W'(w_rd_reg);
            end
            ST_B_M2: begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(delta_reg[j_reg]);
            end
            ST_B_M3: begin
                mul_a = $signed(MUL_W'(lr_reg));
                mul_b = $signed(prod_reg[47:15]);
            end
            default: ;
        endcase
    end

    // z = sat32(acc >>> 15 + bias); table index is the top bits of z + 2^31
    logic signed [31:0]  z_val;
    logic [SIG_AW-1:0]   rom_addr;
    assign z_val    = sat32(SAT_W'($signed(acc_reg[j_reg][ACC_W-1:15])) +
                            SAT_W'(bias_reg[j_reg]));
    assign rom_addr = {~z_val[31], z_val[30 -: SIG_AW-1]};

    logic signed [31:0] bias_new;
    logic signed [31:0] w_new;
    logic signed [31:0] bg_val;
    assign bias_new = sat32(SAT_W'(bias_reg[n_reg]) - SAT_W'($signed(prod_reg[65:32])));
    assign w_new    = sat32(SAT_W'(w_old_reg) - SAT_W'($signed(prod_reg[65:32])));
    assign bg_val   = sat32(SAT_W'($signed(bg_acc_reg[65:32])));

    // memory ports
    logic                    smem_we;
    logic [ROW_W-1:0]        smem_raddr;
    logic                    wmem_we;
    logic [ROW_W+NRN_W-1:0]  wmem_waddr;
    logic signed [WGT_W-1:0] wmem_wdata;
    logic [ROW_W+NRN_W-1:0]  wmem_raddr;

    assign smem_we    = s_accept && (s_op == OP_LOAD) && store_ok;
    assign smem_raddr = (state_reg == ST_B_SRD) ? bp_ptr_reg[ROW_W-1:0] : i_reg;
    assign wmem_raddr = (state_reg == ST_B_WRD) ? {bp_ptr_reg[ROW_W-1:0], j_reg}
                                                : {i_reg, j_reg};

    always_comb begin
        wmem_we    = 1'b0;
        wmem_waddr = {s_row, s_neuron};
        wmem_wdata = s_wval;
        if (state_reg == ST_B_WB) begin
            wmem_we    = 1'b1;
            wmem_waddr = {bp_ptr_reg[ROW_W-1:0], j_reg};
            wmem_wdata = w_new;
        end else if (s_accept && (s_op == OP_WWRITE)) begin
            wmem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (smem_we) smem[eff_count[ROW_W-1:0]] <= s_sample;
        s_rd_reg <= smem[smem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wmem_we) wmem[wmem_waddr] <= wmem_wdata;
        w_rd_reg <= wmem[wmem_raddr];
    end

    always_ff @(posedge aclk) begin
        rom_q_reg <= SIG_TABLE[rom_addr];
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (s_accept && (s_op == OP_LOAD)) begin
            for (int k = 0; k < NUM_OUTPUTS; k++) acc_reg[k] <= '0;
        end
        if (s_accept && (s_op == OP_GRAD)) begin
            g_reg <= s_grad;
            n_reg <= s_neuron;
        end
        if (((state_reg == ST_F_DW) || (state_reg == ST_B_DW)) && div_done) begin
            x_reg <= div_quot;
        end
        if (state_reg == ST_F_ACC) begin
            acc_reg[j_reg] <= acc_reg[j_reg] + ACC_W'($signed(prod_reg[47:0]));
        end
        if (state_reg == ST_B_SRD) bg_acc_reg <= '0;
        if (state_reg == ST_B_M1)  w_old_reg  <= w_rd_reg;
        if (state_reg == ST_B_M2) begin
            bg_acc_reg <= bg_acc_reg + PROD_W'($signed(prod_reg[63:0]));
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            lr_reg          <= LR_RESET;
            count_reg       <= '0;
            max_reg         <= 16'sh8000;
            image_done_reg  <= 1'b0;
            image_valid_reg <= 1'b0;
            bp_ptr_reg      <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            out_valid_reg   <= 1'b0;
            for (int k = 0; k < NUM_OUTPUTS; k++) begin
                bias_reg[k]  <= '0;
                pred_reg[k]  <= '0;
                delta_reg[k] <= '0;
            end
        end else begin
            if (cfg_we) lr_reg <= cfg_wdata;
            if (out_load)      out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        unique case (s_op)
                            OP_LOAD: begin
                                count_reg       <= eff_count + CNT_W'(store_ok);
                                max_reg         <= new_max;
                                image_done_reg  <= s_tlast;
                                image_valid_reg <= s_tlast && (new_max > 0);
                                if (s_tlast) begin
                                    bp_ptr_reg     <= '0;
                                    i_reg          <= '0;
                                    j_reg          <= '0;
                                    if (new_max > 0) begin
                                        state_reg <= ST_F_SRD;
                                    end else begin
                                        state_reg <= ST_ERR;
                                    end
                                end
                            end
                            OP_GRAD: state_reg <= ST_G_M1;
                            OP_BPROP: begin
                                if (image_valid_reg && (bp_ptr_reg < count_reg)) begin
                                    j_reg     <= '0;
                                    state_reg <= ST_B_SRD;
                                end
                            end
                            OP_WWRITE: ;
                            default: ;
                        endcase
                    end
                end
                ST_F_SRD: state_reg <= ST_F_DGO;
                ST_F_DGO: state_reg <= ST_F_DW;
                ST_F_DW:  if (div_done) state_reg <= ST_F_WRD;
                ST_F_WRD: state_reg <= ST_F_MUL;
                ST_F_MUL: state_reg <= ST_F_ACC;
                ST_F_ACC: begin
                    if (j_reg == J_LAST) begin
                        j_reg <= '0;
                        if (walk_end) begin
                            state_reg <= ST_F_ACT;
                        end else begin
                            i_reg     <= i_reg + ROW_W'(1);
                            state_reg <= ST_F_SRD;
                        end
                    end else begin
                        j_reg     <= j_reg + NRN_W'(1);
                        state_reg <= ST_F_WRD;
                    end
                end
                ST_F_ACT: state_reg <= ST_F_PRED;
                ST_F_PRED: begin
                    if (out_free) begin
                        pred_reg[j_reg] <= rom_q_reg;
                        out_kind_reg    <= KIND_PRED;
                        out_nidx_reg    <= j_reg;
                        out_pred_reg    <= rom_q_reg;
                        out_bg_reg      <= '0;
                        out_eidx_reg    <= '0;
                        out_last_reg    <= (j_reg == J_LAST);
                        if (j_reg == J_LAST) begin
                            j_reg     <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            j_reg     <= j_reg + NRN_W'(1);
                            state_reg <= ST_F_ACT;
                        end
                    end
                end
                ST_ERR: begin
                    if (out_free) begin
                        out_kind_reg  <= KIND_ERROR;
                        out_nidx_reg  <= '0;
                        out_pred_reg  <= '0;
                        out_bg_reg    <= '0;
                        out_eidx_reg  <= '0;
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_G_M1: state_reg <= ST_G_M2;
                ST_G_M2: state_reg <= ST_G_M3;
                ST_G_M3: begin
                    delta_reg[n_reg] <= grad_delta;
                    state_reg        <= ST_G_WB;
                end
                ST_G_WB: begin
                    bias_reg[n_reg] <= bias_new;
                    state_reg       <= ST_IDLE;
                end
                ST_B_SRD: state_reg <= ST_B_DGO;
                ST_B_DGO: state_reg <= ST_B_DW;
                ST_B_DW:  if (div_done) state_reg <= ST_B_WRD;
                ST_B_WRD: state_reg <= ST_B_M1;
                ST_B_M1:  state_reg <= ST_B_M2;
                ST_B_M2:  state_reg <= ST_B_M3;
                ST_B_M3:  state_reg <= ST_B_WB;
                ST_B_WB: begin
                    if (j_reg == J_LAST) begin
                        j_reg     <= '0;
                        state_reg <= ST_B_EMIT;
                    end else begin
                        j_reg     <= j_reg + NRN_W'(1);
                        state_reg <= ST_B_WRD;
                    end
                end
                ST_B_EMIT: begin
                    if (out_free) begin
                        out_kind_reg  <= KIND_BGRAD;
                        out_nidx_reg  <= '0;
                        out_pred_reg  <= '0;
                        out_bg_reg    <= bg_val;
                        out_eidx_reg  <= bp_ptr_reg[ROW_W-1:0];
                        out_last_reg  <= bp_last;
                        bp_ptr_reg    <= bp_ptr_reg + CNT_W'(1);
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0, out_eidx_reg, out_bg_reg, out_pred_reg, out_nidx_reg};

endmodule

`default_nettype wire

// ----- hw/rtl/dlst_norm_div.sv -----
// Sample normalizer: trunc(sample * 2^15 / max), saturated to 16 bits.
// Radix-2 restoring divider, one quotient bit per cycle. Uses dlst_pkg.
`default_nettype none

module dlst_norm_div
    import dlst_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [SMP_W-1:0] sample,
    input  wire logic signed [SMP_W-1:0] max_val,   // always positive here
    output logic                         done,
    output logic signed [SMP_W-1:0]      quot
);

    localparam int QW = SMP_W - 1;

    logic                 busy_reg;
    logic                 done_reg;
    logic [3:0]           cnt_reg;
    logic [QW-1:0]        rem_reg;
    logic [QW-1:0]        q_reg;
    logic [QW-1:0]        den_reg;
    logic                 neg_reg;
    logic signed [SMP_W-1:0] quot_reg;

    logic signed [SMP_W:0] neg_max;
    logic signed [SMP_W:0] smp_ext;
    logic [SMP_W:0]        mag;
    logic [QW:0]           r2;
    logic                  ge;
    logic [QW-1:0]         q_next;

    assign neg_max = -(SMP_W+1)'(max_val);
    assign smp_ext = (SMP_W+1)'(sample);
    assign mag     = sample[SMP_W-1] ? 17'(-smp_ext) : 17'(smp_ext);
    assign r2      = {rem_reg, 1'b0};
    assign ge      = r2 >= {1'b0, den_reg};
    assign q_next  = {q_reg[QW-2:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start) begin
                if (sample >= max_val) begin
                    quot_reg <= 16'sh7FFF;
                    done_reg <= 1'b1;
                end else if (smp_ext <= neg_max) begin
                    quot_reg <= 16'sh8000;
                    done_reg <= 1'b1;
                end else begin
                    done_reg <= 1'b0;
                    busy_reg <= 1'b1;
                    cnt_reg  <= 4'(QW);
                    rem_reg  <= mag[QW-1:0];
                    q_reg    <= '0;
                    den_reg  <= max_val[QW-1:0];
                    neg_reg  <= sample[SMP_W-1];
                end
            end else if (busy_reg) begin
                rem_reg  <= ge ? QW'(r2 - {1'b0, den_reg}) : r2[QW-1:0];
                q_reg    <= q_next;
                cnt_reg  <= cnt_reg - 4'd1;
                done_reg <= (cnt_reg == 4'd1);
                if (cnt_reg == 4'd1) begin
                    busy_reg <= 1'b0;
                    quot_reg <= neg_reg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for dense_layer_sigmoid_trainer: directed table, then
// random images, gradients, backprop walks and weight writes against a predictor.
// Depends on dlst_pkg and the trainer RTL.
`default_nettype none

module tb_top;
    import dlst_pkg::*;

    typedef struct {
        op_t                op;
        logic signed [15:0] smp;
        logic               lst;
        logic [1:0]         nrn;
        logic signed [15:0] grad;
        logic [9:0]         row;
        logic signed [31:0] wv;
    } layer_in_t;

    typedef struct {
        kind_t       kind;
        logic [1:0]  nidx;
        logic [15:0] pred;
        logic [31:0] bgrad;
        logic [9:0]  eidx;
        logic        lst;
    } layer_out_t;

    typedef struct {
        layer_in_t  it;
        bit         typed;
        layer_out_t res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [LR_W-1:0] cfg_wdata = '0;

    dense_layer_sigmoid_trainer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // shadow state of the layer
    logic signed [15:0] smp_mem [NUM_INPUTS];
    logic signed [31:0] wgt_mem [NUM_INPUTS*NUM_OUTPUTS];
    logic signed [31:0] bias_r [NUM_OUTPUTS];
    logic [15:0]        pred_r [NUM_OUTPUTS];
    logic signed [31:0] delta_r [NUM_OUTPUTS];
    logic [15:0]        sig_lut [SIG_ENTRIES];
    longint             run_max;
    int                 n_stored;
    int                 walk_ptr;
    bit                 img_done, img_ok;
    longint             lrate;

    layer_out_t results_due[$];
    int  n_fail, n_items, n_results, n_images, n_bad_max, n_bgrads;
    bit  steady;

    function automatic int sat_w32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic void fill_sigmoid();
        longint          xs, e;
        longint unsigned s, term, ue, den, p;
        for (int i = 0; i < SIG_ENTRIES; i++) begin
            xs   = longint'(((64'(2*i+1)) << 31) / SIG_ENTRIES) - (64'sd1 <<< 31);
            s    = (xs < 0) ? -xs : xs;
            e    = 64'sd1 <<< 32;
            term = 64'd1 << 32;
            for (int n = 1; n <= 12; n++) begin
                term = ((term * s) >> 32) / n;
                if (n % 2) e -= longint'(term);
                else       e += longint'(term);
            end
            if (e < 0) e = 0;
            if (e > 64'sh0_FFFF_FFFF) e = 64'sh0_FFFF_FFFF;
            ue = e;
            repeat (4) ue = (ue * ue) >> 32;
            den = (64'd1 << 32) + ue;
            p = (xs >= 0) ? ((64'd1 << 48) / den) : ((ue << 16) / den);
            sig_lut[i] = (p > 65535) ? 16'hFFFF : p[15:0];
        end
    endfunction

    function automatic longint scaled_x(int i);
        longint q;
        q = longint'(smp_mem[i]) * 32768 / run_max;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q;
    endfunction

    function automatic layer_out_t mk_res(kind_t k, int ni, int pv, int bg, int ei, bit l);
        layer_out_t r;
        r.kind = k; r.nidx = 2'(ni); r.pred = 16'(pv); r.bgrad = 32'(bg);
        r.eidx = 10'(ei); r.lst = l;
        return r;
    endfunction

    // layer behavior for one accepted item
    task automatic layer_step(input layer_in_t it, ref layer_out_t outs[$]);
        longint acc, z, x, d, dw;
        int     idx, r;
        case (it.op)
            OP_LOAD: begin
                if (img_done) begin
                    n_stored = 0; run_max = -32768; img_done = 0; img_ok = 0;
                end
                if (n_stored < NUM_INPUTS) begin
                    smp_mem[n_stored] = it.smp;
                    n_stored++;
                    if (longint'(it.smp) > run_max) run_max = it.smp;
                end
                if (it.lst) begin
                    img_done = 1; img_ok = 0; walk_ptr = 0;
                    if (run_max <= 0) begin
                        outs.insert(outs.size(), mk_res(KIND_ERROR, 0, 0, 0, 0, 1));
                    end else begin
                        img_ok = 1;
                        for (int j = 0; j < NUM_OUTPUTS; j++) begin
                            acc = 0;
                            for (int i = 0; i < n_stored; i++)
                                acc += scaled_x(i) * longint'(wgt_mem[i*NUM_OUTPUTS+j]);
                            z = sat_w32((acc >>> 15) + longint'(bias_r[j]));
                            idx = int'((z + (64'sd1 <<< 31)) >>> 22);
                            if (idx >= SIG_ENTRIES) idx = SIG_ENTRIES - 1;
                            pred_r[j] = sig_lut[idx];
                            outs.insert(outs.size(), mk_res(KIND_PRED, j, pred_r[j], 0, 0,
                                                            j == NUM_OUTPUTS-1));
                        end
                    end
                end
            end
            OP_GRAD: begin
                d = longint'(pred_r[it.nrn]) * (65536 - longint'(pred_r[it.nrn]));
                delta_r[it.nrn] = int'((longint'(it.grad) * d) >>> 16);
                bias_r[it.nrn] = sat_w32(longint'(bias_r[it.nrn])
                                         - ((lrate * longint'(delta_r[it.nrn])) >>> 32));
            end
            OP_BPROP: begin
                if (img_ok && walk_ptr < n_stored) begin
                    r = walk_ptr;
                    x = scaled_x(r);
                    acc = 0;
                    for (int j = 0; j < NUM_OUTPUTS; j++)
                        acc += longint'(delta_r[j]) * longint'(wgt_mem[r*NUM_OUTPUTS+j]);
                    for (int j = 0; j < NUM_OUTPUTS; j++) begin
                        dw = (x * longint'(delta_r[j])) >>> 15;
                        wgt_mem[r*NUM_OUTPUTS+j] = sat_w32(longint'(wgt_mem[r*NUM_OUTPUTS+j])
                                                           - ((lrate * dw) >>> 32));
                    end
                    walk_ptr++;
                    outs.insert(outs.size(), mk_res(KIND_BGRAD, 0, 0, sat_w32(acc >>> 32), r,
                                                    walk_ptr == n_stored));
                end
            end
            default: wgt_mem[it.row*NUM_OUTPUTS+it.nrn] = it.wv;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    // every field random, so unused fields toggle too
    function automatic layer_in_t rand_item(op_t op);
        layer_in_t it;
        it.op = op; it.smp = 16'($urandom); it.lst = 1'($urandom_range(0, 1));
        it.nrn = 2'($urandom); it.grad = 16'($urandom); it.row = 10'($urandom);
        it.wv = 32'($urandom);
        return it;
    endfunction

    function automatic layer_in_t mk(op_t op, int sv, bit l, int n, int g, int rw, int w);
        layer_in_t it;
        it.op = op; it.smp = 16'(sv); it.lst = l; it.nrn = 2'(n); it.grad = 16'(g);
        it.row = 10'(rw);
        it.wv = w;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_weight();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
        endcase
    endfunction

    task automatic send(input layer_in_t it, input bit typed, input layer_out_t tres);
        layer_out_t got[$];
        int gap;
        s_tdata  <= {4'b0, it.wv, it.row, it.grad, it.nrn, it.smp};
        s_tuser  <= it.op;
        s_tlast  <= it.lst;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        layer_step(it, got);
        if (typed) results_due.insert(results_due.size(), tres);
        else foreach (got[k]) results_due.insert(results_due.size(), got[k]);
        n_items++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic set_rate(input logic [LR_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        lrate = longint'(v);
    endtask

    // whole images with gradients and backprop walks, plus some stray items
    task automatic random_phase(input int n);
        int stop, len, steps;
        bit nonpos;
        layer_in_t it;
        layer_out_t none;
        stop = n_items + n;
        while (n_items < stop) begin
            if ($urandom_range(0, 99) < 10) begin
                it = rand_item(op_t'($urandom_range(0, 3)));
                if (it.op == OP_LOAD) it.lst = 1'b1; // keep images within written rows
                send(it, 0, none);
            end else begin
                len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 32);
                nonpos = ($urandom_range(0, 9) == 0);
                n_images++;
                for (int i = 0; i < len; i++) begin
                    it = rand_item(OP_LOAD);
                    it.lst = (i == len-1);
                    if (nonpos) it.smp = 16'(-$signed({1'b0, 16'($urandom_range(0, 32768))}));
                    send(it, 0, none);
                end
                for (int j = 0; j < NUM_OUTPUTS; j++)
                    if ($urandom_range(0, 5) != 0) send(rand_item(OP_GRAD), 0, none);
                steps = $urandom_range(0, len + 2);
                for (int i = 0; i < steps; i++) begin
                    if ($urandom_range(0, 9) == 0) send(rand_item(OP_GRAD), 0, none);
                    send(rand_item(OP_BPROP), 0, none);
                end
            end
        end
    endtask

    always @(posedge aclk) begin : result_check
        static int stall = 0;
        layer_out_t e, a;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                a.kind = kind_t'(m_tuser); a.nidx = m_tdata[1:0];
                a.pred = m_tdata[17:2]; a.bgrad = m_tdata[49:18];
                a.eidx = m_tdata[59:50]; a.lst = m_tlast;
                n_results++;
                if (a.kind == KIND_ERROR) n_bad_max++;
                if (a.kind == KIND_BGRAD) n_bgrads++;
                if (results_due.size() == 0) begin
                    $error("unexpected result item kind %0d", a.kind);
                    n_fail++;
                end else begin
                    e = results_due.pop_front();
                    if (a.kind != e.kind) begin
                        $error("kind exp %0d got %0d", e.kind, a.kind); n_fail++;
                    end
                    if (a.nidx != e.nidx) begin
                        $error("neuron_index exp %0d got %0d", e.nidx, a.nidx); n_fail++;
                    end
                    if (a.pred != e.pred) begin
                        $error("prediction exp %h got %h", e.pred, a.pred); n_fail++;
                    end
                    if (a.bgrad != e.bgrad) begin
                        $error("back_gradient exp %h got %h", e.bgrad, a.bgrad); n_fail++;
                    end
                    if (a.eidx != e.eidx) begin
                        $error("element_index exp %0d got %0d", e.eidx, a.eidx); n_fail++;
                    end
                    if (a.lst != e.lst) begin
                        $error("last exp %0d got %0d", e.lst, a.lst); n_fail++;
                    end
                end
            end
            if (stall > 0) begin
                stall = stall - 1;
                m_tready <= 1'b0;
            end else begin
                stall = pick_gap();
                m_tready <= (stall == 0);
            end
        end
    end

    initial begin : run_limit
        #(12 * 3_000_000);
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin : stimulus
        dir_row_t   dir_tab[21];
        layer_out_t none, bad;
        none = mk_res(KIND_PRED, 0, 0, 0, 0, 0);
        bad  = mk_res(KIND_ERROR, 0, 0, 0, 0, 1);
        dir_tab = '{
            '{mk(OP_BPROP, 0, 0, 0, 0, 0, 0), 0, none},          // walk before any image
            '{mk(OP_GRAD, 0, 0, 0, 16'h7FFF, 0, 0), 0, none},
            '{mk(OP_WWRITE, 0, 0, 0, 0, 0, 32'h7FFF_FFFF), 0, none},
            '{mk(OP_WWRITE, 0, 0, 1, 0, 0, 32'h8000_0000), 0, none},
            '{mk(OP_WWRITE, 0, 0, 2, 0, 0, 0), 0, none},
            '{mk(OP_WWRITE, 0, 0, 3, 0, 0, -1), 0, none},
            '{mk(OP_WWRITE, 0, 0, 0, 0, 1, 32'h1000_0000), 0, none},
            '{mk(OP_WWRITE, 0, 0, 1, 0, 1, 32'hF000_0000), 0, none},
            '{mk(OP_WWRITE, 0, 0, 2, 0, 1, 32'h8000_0000), 0, none},
            '{mk(OP_WWRITE, 0, 0, 3, 0, 1, 32'h7FFF_FFFF), 0, none},
            '{mk(OP_LOAD, 16'h7FFF, 0, 0, 0, 0, 0), 0, none},
            '{mk(OP_LOAD, 16'h8000, 1, 0, 0, 0, 0), 0, none},
            '{mk(OP_GRAD, 0, 0, 1, 16'h8000, 0, 0), 0, none},
            '{mk(OP_GRAD, 0, 0, 2, 16'h7FFF, 0, 0), 0, none},
            '{mk(OP_GRAD, 0, 0, 3, 16'h1234, 0, 0), 0, none},
            '{mk(OP_BPROP, 0, 0, 0, 0, 0, 0), 0, none},
            '{mk(OP_BPROP, 0, 0, 0, 0, 0, 0), 0, none},
            '{mk(OP_BPROP, 0, 0, 0, 0, 0, 0), 0, none},          // walk past the end
            '{mk(OP_LOAD, 0, 1, 0, 0, 0, 0), 1, bad},             // max of zero
            '{mk(OP_BPROP, 0, 0, 0, 0, 0, 0), 0, none},          // ignored after error
            '{mk(OP_LOAD, 16'h8000, 1, 0, 0, 0, 0), 1, bad}       // most negative max
        };
        fill_sigmoid();
        lrate = LR_RESET; run_max = -32768; n_stored = 0; walk_ptr = 0;
        img_done = 0; img_ok = 0; steady = 0;
        for (int j = 0; j < NUM_OUTPUTS; j++) begin
            bias_r[j] = 0; pred_r[j] = 0; delta_r[j] = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) send(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

        set_rate(24'hFFFFFF);
        for (int r = 0; r < 32; r++)
            for (int j = 0; j < NUM_OUTPUTS; j++)
                send(mk(OP_WWRITE, $urandom, 1'($urandom_range(0, 1)), j, $urandom, r,
                        rand_weight()), 0, none);
        random_phase(55);
        set_rate(24'h0);
        random_phase(55);
        set_rate(LR_W'($urandom));
        steady = 1;
        random_phase(35);
        steady = 0;
        random_phase(35);

        drain();
        $display("tb_top: %0d items in, %0d results checked over %0d images", n_items,
                 n_results, n_images);
        $display("tb_top: %0d back gradients, %0d bad-maximum errors, 4 learning rates",
                 n_bgrads, n_bad_max);
        if (n_fail == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
